// ===== hdl/slar_pkg.sv =====
`default_nettype none

package slar_pkg;

   // field widths
   localparam int SampleWidth = 12;
   localparam int LevelWidth  = 16;
   localparam int StepWidth   = 3;
   localparam int PotWidth    = 8;
   localparam int VloWidth    = 16;
   localparam int LeadWidth   = $clog2(SampleWidth + 1);
   localparam int MantWidth   = 16;
   localparam int L2Width     = 20;
   localparam int L10Width    = 19;

   localparam int LogTableBitsDefault = 6;

   // log10(2) in q0.20
   localparam logic [18:0] Log10Two = 19'd315653;

   localparam logic signed [VloWidth-1:0] VloReset = -16'sd384;

   // gain steps, 0 is highest gain
   localparam logic [StepWidth-1:0] STEP0 = 3'd0;
   localparam logic [StepWidth-1:0] STEP1 = 3'd1;
   localparam logic [StepWidth-1:0] STEP2 = 3'd2;
   localparam logic [StepWidth-1:0] STEP3 = 3'd3;
   localparam logic [StepWidth-1:0] STEP4 = 3'd4;

   // acceptance windows
   localparam logic [SampleWidth-1:0] Step0High = 12'd600;
   localparam logic [SampleWidth-1:0] Step1Low  = 12'd15;
   localparam logic [SampleWidth-1:0] Step1High = 12'd400;
   localparam logic [SampleWidth-1:0] MidLow    = 12'd20;
   localparam logic [SampleWidth-1:0] MidHigh   = 12'd120;
   localparam logic [SampleWidth-1:0] Step4Low  = 12'd82;

   typedef struct packed {
      logic                 reading_valid;
      logic [StepWidth-1:0] step;
      logic [StepWidth-1:0] new_gain_step;
      logic [PotWidth-1:0]  pot6_setting;
      logic [PotWidth-1:0]  pot7_setting;
      logic                 gain_changed;
      logic                 long_settle;
   } decision_type;

   function automatic logic [PotWidth-1:0] pot6_code(input logic [StepWidth-1:0] step);
      logic [PotWidth-1:0] code;
      unique case (step)
         STEP0:   code = 8'd0;
         STEP1:   code = 8'd7;
         STEP2:   code = 8'd26;
         STEP3:   code = 8'd96;
         default: code = 8'd255;
      endcase
      return code;
   endfunction

   function automatic logic [PotWidth-1:0] pot7_code(input logic [StepWidth-1:0] step);
      logic [PotWidth-1:0] code;
      unique case (step)
         STEP0:   code = 8'd0;
         STEP1:   code = 8'd17;
         STEP2:   code = 8'd97;
         STEP3:   code = 8'd255;
         default: code = 8'd255;
      endcase
      return code;
   endfunction

   // level offset in q7.8
   function automatic logic signed [LevelWidth-1:0] step_offset(
      input logic [StepWidth-1:0] step);
      logic signed [LevelWidth-1:0] ofs;
      unique case (step)
         STEP0:   ofs = 16'sd8448;
         STEP1:   ofs = 16'sd13696;
         STEP2:   ofs = 16'sd17792;
         STEP3:   ofs = 16'sd20224;
         default: ofs = 16'sd20352;
      endcase
      return ofs;
   endfunction

   // slope times two
   function automatic logic [4:0] step_slope(input logic [StepWidth-1:0] step);
      return (step == STEP0 || step == STEP1 || step == STEP2 || step == STEP3) ?
             5'd25 : 5'd27;
   endfunction

   // log2(1 + idx/2^tab_bits) in q0.16 by repeated squaring, elaboration only
   function automatic logic [MantWidth-1:0] mant_log2(input int unsigned idx,
                                                      input int unsigned tab_bits);
      logic [63:0]          m;
      logic [MantWidth-1:0] r;
      m = (64'd1 << tab_bits) + 64'(idx);
      m = m << (30 - tab_bits);
      r = '0;
      for (int k = 0; k < MantWidth; k++) begin
         m = (m * m) >> 30;
         r = {r[MantWidth-2:0], 1'b0};
         if (m >= (64'd1 << 31)) begin
            r[0] = 1'b1;
            m    = m >> 1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/slar_req_if.sv =====
`default_nettype none

interface slar_req_if import slar_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SampleWidth-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/slar_rsp_if.sv =====
`default_nettype none

interface slar_rsp_if import slar_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         reading_valid;
   logic signed [LevelWidth-1:0] level_db;
   logic [StepWidth-1:0]         new_gain_step;
   logic [PotWidth-1:0]          pot6_setting;
   logic [PotWidth-1:0]          pot7_setting;
   logic                         gain_changed;
   logic                         long_settle;

   modport source (output valid, output reading_valid, output level_db,
                   output new_gain_step, output pot6_setting, output pot7_setting,
                   output gain_changed, output long_settle, input ready);
   modport sink   (input valid, input reading_valid, input level_db,
                   input new_gain_step, input pot6_setting, input pot7_setting,
                   input gain_changed, input long_settle, output ready);
endinterface

`default_nettype wire

// ===== hdl/slar_csr_if.sv =====
`default_nettype none

interface slar_csr_if import slar_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VloWidth-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/slar_ranger.sv =====
`default_nettype none

module slar_ranger import slar_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SampleWidth-1:0] sample,
   input  logic                   advance,
   output decision_type           dec
);

   logic [StepWidth-1:0] gain_ff, gain_in;
   logic [StepWidth-1:0] g, ng;
   logic                 vld;

   always_comb begin
      g   = (gain_ff > STEP4) ? STEP4 : gain_ff;
      ng  = g;
      vld = 1'b0;
      unique case (g)
         STEP0: begin
            if (sample <= Step0High) vld = 1'b1;
            else ng = STEP1;
         end
         STEP1: begin
            if (sample < Step1Low) ng = STEP0;
            else if (sample > Step1High) ng = STEP2;
            else vld = 1'b1;
         end
         STEP2, STEP3: begin
            if (sample < MidLow) ng = g - 3'd1;
            else if (sample > MidHigh) ng = g + 3'd1;
            else vld = 1'b1;
         end
         default: begin
            if (sample < Step4Low) ng = STEP3;
            else vld = 1'b1;
         end
      endcase
   end

   always_comb begin
      dec.reading_valid = vld;
      dec.step          = g;
      dec.new_gain_step = ng;
      dec.gain_changed  = (ng != g);
      dec.long_settle   = (ng > g);
      dec.pot6_setting  = (ng != g) ? pot6_code(ng) : '0;
      dec.pot7_setting  = (ng != g) ? pot7_code(ng) : '0;
   end

   assign gain_in = advance ? ng : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= STEP0;
      end else begin
         gain_ff <= gain_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/slar_log2.sv =====
`default_nettype none

module slar_log2 import slar_pkg::*; #(
   parameter int LOG_TABLE_BITS = LogTableBitsDefault
) (
   input  logic [SampleWidth-1:0] sample,
   output logic [L2Width-1:0]     l2
);

   localparam int TabDepth = 2 ** LOG_TABLE_BITS;

   logic [SampleWidth:0]         x, norm;
   logic [LeadWidth-1:0]         e;
   logic [LOG_TABLE_BITS-1:0]    idx;
   logic [MantWidth-1:0]         tab [TabDepth];

   // mantissa table, built at elaboration
   for (genvar j = 0; j < TabDepth; j++) begin : g_tab
      localparam logic [MantWidth-1:0] Entry = mant_log2(j, LOG_TABLE_BITS);
      assign tab[j] = Entry;
   end

   assign x = {1'b0, sample} + (SampleWidth+1)'(1);

   // leading one position
   always_comb begin
      e = '0;
      for (int b = 1; b <= SampleWidth; b++) begin
         if (x[b]) e = LeadWidth'(b);
      end
   end

   // normalize so the leading one sits at the top bit
   assign norm = x << (LeadWidth'(SampleWidth) - e);
   assign idx  = norm[SampleWidth-1 -: LOG_TABLE_BITS];
   assign l2   = {e, MantWidth'(0)} + L2Width'(tab[idx]);

endmodule

`default_nettype wire

// ===== hdl/slar_level.sv =====
`default_nettype none

module slar_level import slar_pkg::*; (
   input  logic                         clock,
   input  logic                         en_mul,
   input  logic                         en_out,
   input  decision_type                 dec,
   input  logic [L2Width-1:0]           l2,
   input  logic signed [VloWidth-1:0]   vlo,
   output decision_type                 dec_out,
   output logic signed [LevelWidth-1:0] level_db
);

   localparam int ProdWidth = L2Width + 20;
   localparam int AccWidth  = 27;

   logic [ProdWidth-1:0]         prod;
   logic [L10Width-1:0]          l10_ff, l10_in;
   decision_type                 dec3_ff;
   decision_type                 dec4_ff;
   logic signed [AccWidth-1:0]   v, scaled, acc, lev;
   logic signed [LevelWidth-1:0] level_ff, level_in;

   // log2 to log10 with rounding
   assign prod   = ProdWidth'(l2) * ProdWidth'(Log10Two) + (ProdWidth'(1) << 19);
   assign l10_in = L10Width'(prod >> 20);

   always_ff @(posedge clock) begin
      if (en_mul) begin
         l10_ff  <= l10_in;
         dec3_ff <= dec;
      end
   end

   // add voltage offset, apply slope, round, divide by 512, add step ofs
   always_comb begin
      v      = $signed(AccWidth'(l10_ff)) + ($signed(AccWidth'(vlo)) <<< 4);
      scaled = v * $signed(AccWidth'(step_slope(dec3_ff.step)));
      acc    = (scaled + AccWidth'(256)) >>> 9;
      lev    = acc + AccWidth'(step_offset(dec3_ff.step));
      if (!dec3_ff.reading_valid) level_in = '0;
      else if (lev > AccWidth'(32767)) level_in = 16'sh7fff;
      else if (lev < -AccWidth'(32768)) level_in = -16'sh8000;
      else level_in = LevelWidth'(lev);
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         level_ff <= level_in;
         dec4_ff  <= dec3_ff;
      end
   end

   assign dec_out  = dec4_ff;
   assign level_db = level_ff;

endmodule

`default_nettype wire

// ===== hdl/sound_level_autorange.sv =====
`default_nettype none

// sound level meter with automatic gain ranging. each req transfer carries one raw adc
// sample of the rectified microphone signal; each one yields exactly one rsp transfer,
// in order. when the sample lies in the window of the current gain step, reading_valid
// is set and level_db gives the level in q7.8 db; otherwise the step moves by one,
// gain_changed is set with the two potentiometer codes of the new step, and
// long_settle flags a move toward lower gain. the block takes one sample per cycle
// while rsp is not stalled, and each sample passes through four registers:
// an input register, the range decision with log2 table lookup, the log10 multiply,
// then slope, offset and saturation into the result register. the gain step update
// sits between the input register and the second stage, which is what
// allows a sample every cycle when the output does not stall.
// csr writes set the voltage log offset (q3.12, reset -384) and should only happen
// while the pipeline is empty.
module sound_level_autorange import slar_pkg::*; #(
   parameter int LOG_TABLE_BITS = LogTableBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   slar_req_if.sink   req,
   slar_rsp_if.source rsp,
   slar_csr_if.sink   csr
);

   // configuration
   logic signed [VloWidth-1:0] vlo_ff, vlo_in;

   // stage valids
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // payload
   logic [SampleWidth-1:0] sample_ff;
   decision_type           dec, dec2_ff, dec_out;
   logic [L2Width-1:0]     l2, l2_ff;
   logic signed [LevelWidth-1:0] level_db;
   logic                   advance;

   // each stage takes a new item when empty or when its content moves on
   assign rdy4 = !v4_ff || rsp.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req.ready = rdy1;
   assign csr.ready = 1'b1;

   // gain step moves only when the decided item leaves the input register
   assign advance = v1_ff && rdy2;

   assign v1_in  = rdy1 ? req.valid : v1_ff;
   assign v2_in  = rdy2 ? v1_ff : v2_ff;
   assign v3_in  = rdy3 ? v2_ff : v3_ff;
   assign v4_in  = rdy4 ? v3_ff : v4_ff;
   assign vlo_in = csr.valid ? csr.data : vlo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         vlo_ff <= VloReset;
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         v4_ff  <= v4_in;
         vlo_ff <= vlo_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (rdy1) begin
         sample_ff <= req.sample;
      end
   end

   // range decision and gain state
   slar_ranger u_ranger (
      .clock   (clock),
      .reset   (reset),
      .sample  (sample_ff),
      .advance (advance),
      .dec     (dec)
   );

   // log2 of sample plus one
   slar_log2 #(
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_log2 (
      .sample (sample_ff),
      .l2     (l2)
   );

   // decision stage register
   always_ff @(posedge clock) begin
      if (rdy2) begin
         dec2_ff <= dec;
         l2_ff   <= l2;
      end
   end

   // log10 multiply and level stages, result register inside
   slar_level u_level (
      .clock    (clock),
      .en_mul   (rdy3),
      .en_out   (rdy4),
      .dec      (dec2_ff),
      .l2       (l2_ff),
      .vlo      (vlo_ff),
      .dec_out  (dec_out),
      .level_db (level_db)
   );

   assign rsp.valid         = v4_ff;
   assign rsp.reading_valid = dec_out.reading_valid;
   assign rsp.level_db      = level_db;
   assign rsp.new_gain_step = dec_out.new_gain_step;
   assign rsp.pot6_setting  = dec_out.pot6_setting;
   assign rsp.pot7_setting  = dec_out.pot7_setting;
   assign rsp.gain_changed  = dec_out.gain_changed;
   assign rsp.long_settle   = dec_out.long_settle;

   // a valid reading never comes with a step move
   a_valid_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.reading_valid |-> !rsp.gain_changed)
      else $error("valid reading with gain change");

   // an out of window sample reports a zero level
   a_zero_level: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.reading_valid |-> rsp.level_db == 16'sd0)
      else $error("nonzero level on out of window sample");

   // pot codes and settle flag only with a step move
   a_quiet_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.gain_changed |->
      rsp.pot6_setting == 8'd0 && rsp.pot7_setting == 8'd0 && !rsp.long_settle)
      else $error("pot codes without gain change");

   // step stays within range
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.new_gain_step <= STEP4)
      else $error("gain step out of range");

endmodule

`default_nettype wire

// ===== tb/sv/tb_sound_level_autorange.sv =====
`default_nettype none

module tb_sound_level_autorange;
   import slar_pkg::*;

   // width of the log2 mantissa table index, as the block is built
   localparam int TableBits = LogTableBitsDefault;
   localparam int TableSize = 1 << TableBits;

   // idle cycles added once every prediction has been met
   localparam int SettleCycles = 12;

   // one rsp transfer as the block should present it
   typedef struct packed {
      logic                         reading_valid;
      logic signed [LevelWidth-1:0] level_db;
      logic [StepWidth-1:0]         new_gain_step;
      logic [PotWidth-1:0]          pot6_setting;
      logic [PotWidth-1:0]          pot7_setting;
      logic                         gain_changed;
      logic                         long_settle;
   } meter_reading_type;

   // receiver stall patterns
   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // tracks the gain step and the voltage offset, predicts each reading and
   // checks the readings that come back, in order
   class autorange_tracker;
      logic [StepWidth-1:0]       gain;
      logic signed [VloWidth-1:0] vlo;
      logic [MantWidth-1:0]       mant_table [TableSize];
      int                         step_ofs [5];
      logic [PotWidth-1:0]        pot6_by_step [5];
      logic [PotWidth-1:0]        pot7_by_step [5];
      meter_reading_type          pending_readings [$];
      int                         failures;

      function new();
         longint unsigned m;
         logic [MantWidth-1:0] r;
         // log2(1 + i/2^bits) in q0.16 by repeated squaring of the mantissa
         for (int i = 0; i < TableSize; i++) begin
            m = (longint'(TableSize) + longint'(i)) << (30 - TableBits);
            r = '0;
            for (int k = 0; k < MantWidth; k++) begin
               m = (m * m) >> 30;
               r = {r[MantWidth-2:0], 1'b0};
               if (m >= (64'd1 << 31)) begin
                  r[0] = 1'b1;
                  m    = m >> 1;
               end
            end
            mant_table[i] = r;
         end
         step_ofs     = '{8448, 13696, 17792, 20224, 20352};
         pot6_by_step = '{8'd0, 8'd7, 8'd26, 8'd96, 8'd255};
         pot7_by_step = '{8'd0, 8'd17, 8'd97, 8'd255, 8'd255};
         gain         = STEP0;
         vlo          = VloReset;
         failures     = 0;
      endfunction

      function void set_offset(input logic signed [VloWidth-1:0] value);
         vlo = value;
      endfunction

      function int pending();
         return pending_readings.size();
      endfunction

      // level in q7.8 db for a sample taken at gain step g
      function logic signed [LevelWidth-1:0] level_for(input logic [SampleWidth-1:0] s,
                                                        input logic [StepWidth-1:0] g);
         int unsigned     x, lead, idx;
         longint unsigned l2, l10;
         longint          v, lev;
         x    = s + 1;
         lead = 0;
         while (lead < 31 && (x >> (lead + 1)) != 0)
            lead++;
         // the bits under the leading one index the mantissa table
         if (lead >= TableBits)
            idx = (x >> (lead - TableBits)) & (TableSize - 1);
         else
            idx = (x << (TableBits - lead)) & (TableSize - 1);
         l2  = (longint'(lead) << 16) + longint'(mant_table[idx]);
         l10 = (l2 * longint'(Log10Two) + (64'd1 << 19)) >> 20;
         v   = longint'(l10) + longint'(vlo) * 16;
         // slope is kept doubled, so round and divide by 512 with floor
         lev = ((v * ((g == STEP4) ? 27 : 25) + 256) >>> 9) + step_ofs[g];
         if (lev > 32767)
            lev = 32767;
         if (lev < -32768)
            lev = -32768;
         return LevelWidth'(lev);
      endfunction

      function void note_sample(input logic [SampleWidth-1:0] s);
         logic [StepWidth-1:0] g, ng;
         meter_reading_type    exp;
         g  = (gain > STEP4) ? STEP4 : gain;
         ng = g;
         exp = '0;
         case (g)
            STEP0: begin
               if (s <= Step0High) exp.reading_valid = 1'b1;
               else ng = STEP1;
            end
            STEP1: begin
               if (s < Step1Low) ng = STEP0;
               else if (s > Step1High) ng = STEP2;
               else exp.reading_valid = 1'b1;
            end
            STEP2, STEP3: begin
               if (s < MidLow) ng = g - 3'd1;
               else if (s > MidHigh) ng = g + 3'd1;
               else exp.reading_valid = 1'b1;
            end
            default: begin
               if (s < Step4Low) ng = STEP3;
               else exp.reading_valid = 1'b1;
            end
         endcase
         if (exp.reading_valid)
            exp.level_db = level_for(s, g);
         exp.new_gain_step = ng;
         if (ng != g) begin
            exp.pot6_setting = pot6_by_step[ng];
            exp.pot7_setting = pot7_by_step[ng];
            exp.gain_changed = 1'b1;
            exp.long_settle  = (ng > g);
         end
         gain = ng;
         pending_readings.push_back(exp);
      endfunction

      function void check_reading(input meter_reading_type got);
         meter_reading_type exp;
         bit                bad;
         if (pending_readings.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("error: reading with none outstanding, level=%0d step=%0d",
                        got.level_db, got.new_gain_step);
            return;
         end
         exp = pending_readings.pop_front();
         bad = (got.reading_valid !== exp.reading_valid) ||
               (got.level_db      !== exp.level_db)      ||
               (got.new_gain_step !== exp.new_gain_step) ||
               (got.pot6_setting  !== exp.pot6_setting)  ||
               (got.pot7_setting  !== exp.pot7_setting)  ||
               (got.gain_changed  !== exp.gain_changed)  ||
               (got.long_settle   !== exp.long_settle);
         if (bad) begin
            failures++;
            if (failures <= 10) begin
               $display("error: exp valid=%0d level=%0d step=%0d pot6=%0d pot7=%0d chg=%0d ls=%0d",
                        exp.reading_valid, exp.level_db, exp.new_gain_step,
                        exp.pot6_setting, exp.pot7_setting, exp.gain_changed, exp.long_settle);
               $display("       got valid=%0d level=%0d step=%0d pot6=%0d pot7=%0d chg=%0d ls=%0d",
                        got.reading_valid, got.level_db, got.new_gain_step,
                        got.pot6_setting, got.pot7_setting, got.gain_changed, got.long_settle);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   slar_req_if req_if ();
   slar_rsp_if rsp_if ();
   slar_csr_if csr_if ();

   sound_level_autorange u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   autorange_tracker tracker = new();

   // sender burst state
   int burst_left = 0;

   // receiver stall state
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_tick = 0;

   // directed walk: window edges of every step, every move up and down,
   // the top step taking a full-scale sample, then back down to step 0
   localparam logic [SampleWidth-1:0] DirectedSamples [26] = '{
      12'd0,   12'd600, 12'd601,              // step 0 edges, move up
      12'd15,  12'd400, 12'd14,               // step 1 edges, move down
      12'd601, 12'd401,                       // up twice
      12'd20,  12'd120, 12'd19,               // edges of step 2, down
      12'd401, 12'd121,                       // back up to step 3
      12'd20,  12'd120, 12'd19,               // edges of step 3, down
      12'd121, 12'd121,                       // up to the top step
      12'd82,  12'd4095, 12'd81,              // top step edges, full scale
      12'd121, 12'd0,                         // up again, then down
      12'd0,   12'd0,   12'd0                 // all the way back to step 0
   };

   // voltage offsets for the later phases, extremes first
   localparam int PhaseCount = 6;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // safety net against a hung handshake
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver: ready follows a stall pattern that is drawn anew at random at regular intervals
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 300 == 0)
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_NONE:     rsp_if.ready <= 1'b1;
            STALL_RANDOM:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_if.ready <= (stall_tick % 7 < 4);
            default:        rsp_if.ready <= ($urandom_range(0, 9) < 2);
         endcase
      end
   end

   // every rsp transfer is checked against the oldest prediction
   always @(posedge clock) begin
      meter_reading_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.reading_valid = rsp_if.reading_valid;
         got.level_db      = rsp_if.level_db;
         got.new_gain_step = rsp_if.new_gain_step;
         got.pot6_setting  = rsp_if.pot6_setting;
         got.pot7_setting  = rsp_if.pot7_setting;
         got.gain_changed  = rsp_if.gain_changed;
         got.long_settle   = rsp_if.long_settle;
         tracker.check_reading(got);
      end
   end

   // one req transfer; valid stays high across a burst and drops for gaps
   task automatic send_sample(input logic [SampleWidth-1:0] s);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 10);
         burst_left = $urandom_range(1, 40);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      do @(posedge clock); while (!req_if.ready);
      // transfer happened at this edge, the prediction follows it at once
      tracker.note_sample(s);
   endtask

   // hold off the sender until every prediction has been met
   task automatic drain_readings();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // register write, only ever issued with the pipeline empty
   task automatic write_offset(input logic signed [VloWidth-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      tracker.set_offset(value);
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      logic signed [VloWidth-1:0] phase_vlo [PhaseCount];
      logic [SampleWidth-1:0]     s;
      int                         pick;

      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.sample <= '0;
      csr_if.valid  <= 1'b0;
      csr_if.data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed walk runs on the reset value of the offset
      foreach (DirectedSamples[n])
         send_sample(DirectedSamples[n]);
      drain_readings();

      // largest positive offset drives the top step into saturation
      phase_vlo[0] = 16'sh7fff;
      phase_vlo[1] = -16'sh8000;
      phase_vlo[2] = 16'sh0000;
      phase_vlo[3] = VloWidth'($urandom_range(0, 65535));
      phase_vlo[4] = VloReset;
      phase_vlo[5] = VloWidth'($urandom_range(0, 65535));

      for (int p = 0; p < PhaseCount; p++) begin
         write_offset(phase_vlo[p]);
         for (int n = 0; n < 205; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               // inside the window of the current step, keeps the step
               case (tracker.gain)
                  STEP0:        s = SampleWidth'($urandom_range(0, 600));
                  STEP1:        s = SampleWidth'($urandom_range(15, 400));
                  STEP2, STEP3: s = SampleWidth'($urandom_range(20, 120));
                  default:      s = SampleWidth'($urandom_range(82, 4095));
               endcase
            end else if (pick < 75) begin
               // window edges of all steps
               case ($urandom_range(0, 13))
                  0:       s = 12'd0;
                  1:       s = 12'd14;
                  2:       s = 12'd15;
                  3:       s = 12'd19;
                  4:       s = 12'd20;
                  5:       s = 12'd81;
                  6:       s = 12'd82;
                  7:       s = 12'd120;
                  8:       s = 12'd121;
                  9:       s = 12'd400;
                  10:      s = 12'd401;
                  11:      s = 12'd600;
                  12:      s = 12'd601;
                  default: s = 12'd4095;
               endcase
            end else if (pick < 90) begin
               // outside the middle windows; moves the step while at step 2 or 3
               s = SampleWidth'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 19)
                                                            : $urandom_range(121, 700));
            end else begin
               s = SampleWidth'($urandom_range(0, 4095));
            end
            send_sample(s);
            // mid-phase pause with the sender fully quiet
            if (p == 2 && n == 100)
               drain_readings();
         end
         drain_readings();
      end

      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
